// ----- rtl/core/clns_pkg.sv -----
// Shared types, codes and constants for the character LCD nibble sequencer.
package clns_pkg;

   localparam int unsigned OPCODE_W    = 3;
   localparam int unsigned VALUE_W     = 8;
   localparam int unsigned ROW_W       = 3;
   localparam int unsigned COLUMN_W    = 5;
   localparam int unsigned NIBBLE_W    = 4;
   localparam int unsigned DURATION_W  = 16;
   localparam int unsigned PULSE_W     = 10;
   localparam int unsigned SETTLE_W    = 12;
   localparam int unsigned CSR_DATA_W  = 12;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [PULSE_W-1:0]  PULSE_RESET  = PULSE_W'(50);
   localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(250);

   localparam logic [DURATION_W-1:0] INIT_LEAD_US  = DURATION_W'(40000);
   localparam logic [DURATION_W-1:0] INIT_TAIL_US  = DURATION_W'(5000);
   localparam logic [DURATION_W-1:0] CLEAR_TAIL_US = DURATION_W'(2000);

   localparam int unsigned INIT_CMD_COUNT = 6;
   localparam int unsigned INIT_IDX_W     = $clog2(INIT_CMD_COUNT);
   localparam logic [INIT_IDX_W-1:0] INIT_IDX_LAST = INIT_IDX_W'(INIT_CMD_COUNT - 1);

   localparam logic [VALUE_W-1:0] CMD_CLEAR      = 8'h01;
   localparam logic [VALUE_W-1:0] CMD_CURSOR_ON  = 8'h0F;
   localparam logic [VALUE_W-1:0] CMD_CURSOR_OFF = 8'h0C;
   localparam logic [VALUE_W-1:0] ADDR_BASE_LOW  = 8'h7F;  // 0x80 - 1
   localparam logic [VALUE_W-1:0] ADDR_BASE_HIGH = 8'h93;  // 0x80 + 20 - 1

   localparam logic EV_STROBE = 1'b0;
   localparam logic EV_WAIT   = 1'b1;
   localparam logic RS_INSTR  = 1'b0;
   localparam logic RS_DATA   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_PULSE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE       = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INIT    = 3'd0,
      OP_COMMAND = 3'd1,
      OP_DATA    = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_SETPOS  = 3'd4,
      OP_CURSOR  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      JOB_BYTE,
      JOB_INIT,
      JOB_CLEAR
   } job_kind_type;

   typedef struct packed {
      job_kind_type        kind;
      logic                rs;
      logic [VALUE_W-1:0]  data;
   } job_type;

   typedef struct packed {
      logic [PULSE_W-1:0]  enable_pulse_us;
      logic [SETTLE_W-1:0] settle_us;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD,
      ST_HIGH,
      ST_LOW,
      ST_SETTLE,
      ST_TAIL
   } state_type;

   function automatic logic [VALUE_W-1:0] init_cmd(input logic [INIT_IDX_W-1:0] idx);
      logic [VALUE_W-1:0] cmd;
      case (idx)
         3'd0:    cmd = 8'h03;
         3'd1:    cmd = 8'h02;
         3'd2:    cmd = 8'h28;
         3'd3:    cmd = 8'h0C;
         3'd4:    cmd = 8'h06;
         default: cmd = 8'h01;
      endcase
      return cmd;
   endfunction

endpackage

// ----- rtl/core/clns_front.sv -----
// Front end: takes requests, decodes them into byte jobs and pushes them to the queue.
module clns_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [clns_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [clns_pkg::VALUE_W-1:0]  req_value,
   input  logic [clns_pkg::ROW_W-1:0]    req_row,
   input  logic [clns_pkg::COLUMN_W-1:0] req_column,
   input  logic                          q_full,
   output logic                          q_push,
   output clns_pkg::job_type             q_push_data
);

   logic                         known;
   logic [clns_pkg::VALUE_W-1:0] addr;
   logic [1:0]                   row_sel;

   // row offset is (row-1) or (row-3), times 0x40, modulo 256
   always_comb begin
      if (req_row < clns_pkg::ROW_W'(3)) begin
         row_sel = req_row[1:0] - 2'd1;
         addr    = {row_sel, 6'd0} + {3'd0, req_column} + clns_pkg::ADDR_BASE_LOW;
      end else begin
         row_sel = req_row[1:0] - 2'd3;
         addr    = {row_sel, 6'd0} + {3'd0, req_column} + clns_pkg::ADDR_BASE_HIGH;
      end
   end

   always_comb begin
      known             = 1'b1;
      q_push_data.kind  = clns_pkg::JOB_BYTE;
      q_push_data.rs    = clns_pkg::RS_INSTR;
      q_push_data.data  = req_value;
      unique case (req_opcode)
         clns_pkg::OP_INIT: begin
            q_push_data.kind = clns_pkg::JOB_INIT;
         end
         clns_pkg::OP_COMMAND: begin
         end
         clns_pkg::OP_DATA: begin
            q_push_data.rs = clns_pkg::RS_DATA;
         end
         clns_pkg::OP_CLEAR: begin
            q_push_data.kind = clns_pkg::JOB_CLEAR;
            q_push_data.data = clns_pkg::CMD_CLEAR;
         end
         clns_pkg::OP_SETPOS: begin
            q_push_data.data = addr;
         end
         clns_pkg::OP_CURSOR: begin
            q_push_data.data = req_value[0] ? clns_pkg::CMD_CURSOR_ON
                                            : clns_pkg::CMD_CURSOR_OFF;
         end
         default: begin
            known = 1'b0;  // reserved opcodes are taken and dropped
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && known;

endmodule

// ----- rtl/core/clns_queue.sv -----
// Small job queue between the decoder and the event sequencer.
module clns_queue #(
   parameter int unsigned DEPTH = clns_pkg::QUEUE_DEPTH_DEFAULT  // 2 or more
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clns_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output clns_pkg::job_type pop_data,
   output logic              empty
);

   localparam int unsigned PTR_W   = $clog2(DEPTH);
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   clns_pkg::job_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic               do_push, do_pop;

   assign full     = count_ff == COUNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/clns_back.sv -----
// Back end: walks one job through its strobe and wait events into the result register.
module clns_back (
   input  logic                            clock,
   input  logic                            reset,
   input  clns_pkg::cfg_type               cfg,
   input  logic                            q_empty,
   input  clns_pkg::job_type               q_pop_data,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_event_kind,
   output logic                            rsp_reg_select,
   output logic [clns_pkg::NIBBLE_W-1:0]   rsp_nibble,
   output logic [clns_pkg::DURATION_W-1:0] rsp_duration_us,
   output logic                            rsp_last
);

   clns_pkg::state_type             state_ff, state_in;
   clns_pkg::job_type               job_ff;
   logic [clns_pkg::INIT_IDX_W-1:0] idx_ff, idx_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            kind_ff, kind_in;
   logic                            rs_ff, rs_in;
   logic [clns_pkg::NIBBLE_W-1:0]   nibble_ff, nibble_in;
   logic [clns_pkg::DURATION_W-1:0] dur_ff, dur_in;
   logic                            last_ff, last_in;

   logic                            load, emit;
   logic                            is_init;
   logic [clns_pkg::VALUE_W-1:0]    cur_byte;
   logic [clns_pkg::DURATION_W-1:0] pulse_dur, settle_dur;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign is_init    = job_ff.kind == clns_pkg::JOB_INIT;
   assign cur_byte   = is_init ? clns_pkg::init_cmd(idx_ff) : job_ff.data;
   assign pulse_dur  = clns_pkg::DURATION_W'(cfg.enable_pulse_us);
   assign settle_dur = clns_pkg::DURATION_W'(cfg.settle_us);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clns_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = (q_pop_data.kind == clns_pkg::JOB_INIT) ? clns_pkg::ST_LEAD
                                                                  : clns_pkg::ST_HIGH;
            end
         end
         clns_pkg::ST_LEAD: begin
            if (load) state_in = clns_pkg::ST_HIGH;
         end
         clns_pkg::ST_HIGH: begin
            if (load) state_in = clns_pkg::ST_LOW;
         end
         clns_pkg::ST_LOW: begin
            if (load) state_in = clns_pkg::ST_SETTLE;
         end
         clns_pkg::ST_SETTLE: begin
            if (load) begin
               if (is_init && idx_ff != clns_pkg::INIT_IDX_LAST) begin
                  state_in = clns_pkg::ST_HIGH;
               end else if (job_ff.kind == clns_pkg::JOB_BYTE) begin
                  state_in = clns_pkg::ST_IDLE;
               end else begin
                  state_in = clns_pkg::ST_TAIL;
               end
            end
         end
         clns_pkg::ST_TAIL: begin
            if (load) state_in = clns_pkg::ST_IDLE;
         end
         default: state_in = clns_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      emit      = 1'b0;
      idx_in    = idx_ff;
      kind_in   = clns_pkg::EV_WAIT;
      rs_in     = job_ff.rs;
      nibble_in = '0;
      dur_in    = settle_dur;
      last_in   = 1'b0;
      unique case (state_ff)
         clns_pkg::ST_IDLE: begin
            q_pop  = !q_empty;
            idx_in = '0;
         end
         clns_pkg::ST_LEAD: begin
            emit   = load;
            rs_in  = clns_pkg::RS_INSTR;
            dur_in = clns_pkg::INIT_LEAD_US;
         end
         clns_pkg::ST_HIGH: begin
            emit      = load;
            kind_in   = clns_pkg::EV_STROBE;
            nibble_in = cur_byte[7:4];
            dur_in    = pulse_dur;
         end
         clns_pkg::ST_LOW: begin
            emit      = load;
            kind_in   = clns_pkg::EV_STROBE;
            nibble_in = cur_byte[3:0];
            dur_in    = pulse_dur;
         end
         clns_pkg::ST_SETTLE: begin
            emit    = load;
            last_in = job_ff.kind == clns_pkg::JOB_BYTE;
            if (load && is_init && idx_ff != clns_pkg::INIT_IDX_LAST) begin
               idx_in = idx_ff + clns_pkg::INIT_IDX_W'(1);
            end
         end
         clns_pkg::ST_TAIL: begin
            emit    = load;
            rs_in   = clns_pkg::RS_DATA;
            dur_in  = is_init ? clns_pkg::INIT_TAIL_US : clns_pkg::CLEAR_TAIL_US;
            last_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load ? emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clns_pkg::ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_pop_data;
      end
      if (emit) begin
         kind_ff   <= kind_in;
         rs_ff     <= rs_in;
         nibble_ff <= nibble_in;
         dur_ff    <= dur_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_reg_select  = rs_ff;
   assign rsp_nibble      = nibble_ff;
   assign rsp_duration_us = dur_ff;
   assign rsp_last        = last_ff;

endmodule

// ----- rtl/core/char_lcd_nibble_sequencer_top.sv -----
// Top level of the character LCD nibble sequencer: registers, decoder, queue, sequencer.
//
//   port group | direction | handshake        | carries
//   req_*      | in        | valid / stall    | opcode, value, row, column
//   rsp_*      | out       | valid / stall    | event_kind, reg_select, nibble, duration_us, last
//   csr_*      | in        | write enable     | index 0 enable pulse, 1 settle
//
// One event per cycle while the result side takes them; each job first leaves the queue
// in the idle state, which makes no event.
// Requests are taken while the queue has room, so decoding overlaps the running job.
// Synchronous reset empties the queue and result register and restores 50 us / 250 us.
// A stall on rsp holds the sequencer; reserved opcodes are taken and make no events.
module char_lcd_nibble_sequencer_top #(
   parameter int unsigned QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [clns_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [clns_pkg::VALUE_W-1:0]      req_value,
   input  logic [clns_pkg::ROW_W-1:0]        req_row,
   input  logic [clns_pkg::COLUMN_W-1:0]     req_column,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_event_kind,
   output logic                              rsp_reg_select,
   output logic [clns_pkg::NIBBLE_W-1:0]     rsp_nibble,
   output logic [clns_pkg::DURATION_W-1:0]   rsp_duration_us,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [clns_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [clns_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   clns_pkg::cfg_type cfg_ff, cfg_in;
   clns_pkg::job_type push_data, pop_data;
   logic              q_full, q_empty, q_push, q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            clns_pkg::CSR_ENABLE_PULSE:
               cfg_in.enable_pulse_us = csr_wdata[clns_pkg::PULSE_W-1:0];
            clns_pkg::CSR_SETTLE:
               cfg_in.settle_us = csr_wdata[clns_pkg::SETTLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_us <= clns_pkg::PULSE_RESET;
         cfg_ff.settle_us       <= clns_pkg::SETTLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clns_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_value   (req_value),
      .req_row     (req_row),
      .req_column  (req_column),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (push_data)
   );

   clns_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   clns_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_pop_data      (pop_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_nibble      (rsp_nibble),
      .rsp_duration_us (rsp_duration_us),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- bench/char_lcd_nibble_sequencer_top_tb.sv -----
// Self-checking testbench for char_lcd_nibble_sequencer_top: directed table, then random requests.
module char_lcd_nibble_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import clns_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;
   localparam int unsigned QUIET_CYCLES   = 30;
   localparam int unsigned IDLE_LIMIT     = 2000;
   localparam int unsigned ITEMS_PER_PASS = 84;
   localparam logic [47:0] LCD_INIT_SEQ   = 48'h03_02_28_0C_06_01;

   typedef struct packed {
      logic                  kind;
      logic                  rs;
      logic [NIBBLE_W-1:0]   nibble;
      logic [DURATION_W-1:0] duration;
      logic                  last;
   } lcd_event_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [VALUE_W-1:0]  value;
      logic [ROW_W-1:0]    row;
      logic [COLUMN_W-1:0] column;
      logic                typed;
      logic [1:0]          n_typed;
      lcd_event_type       ev0;
      lcd_event_type       ev1;
      lcd_event_type       ev2;
   } stim_row_type;

   localparam lcd_event_type NO_EV = '0;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [OPCODE_W-1:0]     req_opcode;
   logic [VALUE_W-1:0]      req_value;
   logic [ROW_W-1:0]        req_row;
   logic [COLUMN_W-1:0]     req_column;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic                    rsp_event_kind;
   logic                    rsp_reg_select;
   logic [NIBBLE_W-1:0]     rsp_nibble;
   logic [DURATION_W-1:0]   rsp_duration_us;
   logic                    rsp_last;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   lcd_event_type    lcd_events_due [$];
   logic [PULSE_W-1:0]  pulse_us;
   logic [SETTLE_W-1:0] settle_us;
   int unsigned      failures    = 0;
   int unsigned      items_sent  = 0;
   int unsigned      events_seen = 0;
   int unsigned      gap_pct;
   int unsigned      stall_pct;
   bit               calm;

   wire any_taken = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);

   // reset timing (50/250) for the typed rows
   stim_row_type dir_tab [21] = '{
      '{OP_INIT,    8'h00, 3'd1, 5'd1,  1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_COMMAND, 8'hFF, 3'd0, 5'd0,  1'b1, 2'd3,
        '{EV_STROBE, RS_INSTR, 4'hF, 16'd50, 1'b0},
        '{EV_STROBE, RS_INSTR, 4'hF, 16'd50, 1'b0},
        '{EV_WAIT,   RS_INSTR, 4'h0, 16'd250, 1'b1}},
      '{OP_COMMAND, 8'h00, 3'd7, 5'd31, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_DATA,    8'h00, 3'd0, 5'd0,  1'b1, 2'd3,
        '{EV_STROBE, RS_DATA, 4'h0, 16'd50, 1'b0},
        '{EV_STROBE, RS_DATA, 4'h0, 16'd50, 1'b0},
        '{EV_WAIT,   RS_DATA, 4'h0, 16'd250, 1'b1}},
      '{OP_DATA,    8'hFF, 3'd7, 5'd31, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_DATA,    8'hA5, 3'd2, 5'd10, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_CLEAR,   8'h5A, 3'd5, 5'd21, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_SETPOS,  8'h00, 3'd1, 5'd1,  1'b1, 2'd3,
        '{EV_STROBE, RS_INSTR, 4'h8, 16'd50, 1'b0},
        '{EV_STROBE, RS_INSTR, 4'h0, 16'd50, 1'b0},
        '{EV_WAIT,   RS_INSTR, 4'h0, 16'd250, 1'b1}},
      '{OP_SETPOS,  8'hFF, 3'd2, 5'd20, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_SETPOS,  8'h00, 3'd3, 5'd1,  1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_SETPOS,  8'h00, 3'd4, 5'd20, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_SETPOS,  8'h00, 3'd0, 5'd0,  1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_SETPOS,  8'h00, 3'd7, 5'd31, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_SETPOS,  8'h00, 3'd5, 5'd21, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_CURSOR,  8'h01, 3'd0, 5'd0,  1'b1, 2'd3,
        '{EV_STROBE, RS_INSTR, 4'h0, 16'd50, 1'b0},
        '{EV_STROBE, RS_INSTR, 4'hF, 16'd50, 1'b0},
        '{EV_WAIT,   RS_INSTR, 4'h0, 16'd250, 1'b1}},
      '{OP_CURSOR,  8'hFE, 3'd0, 5'd0,  1'b1, 2'd3,
        '{EV_STROBE, RS_INSTR, 4'h0, 16'd50, 1'b0},
        '{EV_STROBE, RS_INSTR, 4'hC, 16'd50, 1'b0},
        '{EV_WAIT,   RS_INSTR, 4'h0, 16'd250, 1'b1}},
      '{OP_CURSOR,  8'hFF, 3'd7, 5'd31, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_RSVD6,   8'hFF, 3'd7, 5'd31, 1'b1, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_RSVD7,   8'h00, 3'd0, 5'd0,  1'b1, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_COMMAND, 8'h5A, 3'd7, 5'd31, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV},
      '{OP_INIT,    8'hFF, 3'd7, 5'd31, 1'b0, 2'd0, NO_EV, NO_EV, NO_EV}
   };

   char_lcd_nibble_sequencer_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_row         (req_row),
      .req_column      (req_column),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_nibble      (rsp_nibble),
      .rsp_duration_us (rsp_duration_us),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_byte(input logic rs, input logic [VALUE_W-1:0] b);
      lcd_events_due.push_back(
         lcd_event_type'{EV_STROBE, rs, b[7:4], DURATION_W'(pulse_us), 1'b0});
      lcd_events_due.push_back(
         lcd_event_type'{EV_STROBE, rs, b[3:0], DURATION_W'(pulse_us), 1'b0});
      lcd_events_due.push_back(
         lcd_event_type'{EV_WAIT, rs, 4'h0, DURATION_W'(settle_us), 1'b0});
   endfunction

   function automatic void predict_events(input stim_row_type r);
      int due_before;
      int addr;
      due_before = lcd_events_due.size();
      case (r.opcode)
         OP_INIT: begin
            lcd_events_due.push_back(
               lcd_event_type'{EV_WAIT, RS_INSTR, 4'h0, 16'd40000, 1'b0});
            for (int i = 0; i < 6; i++)
               queue_byte(RS_INSTR, LCD_INIT_SEQ[47 - 8*i -: 8]);
            lcd_events_due.push_back(
               lcd_event_type'{EV_WAIT, RS_DATA, 4'h0, 16'd5000, 1'b0});
         end
         OP_COMMAND: queue_byte(RS_INSTR, r.value);
         OP_DATA:    queue_byte(RS_DATA, r.value);
         OP_CLEAR: begin
            queue_byte(RS_INSTR, 8'h01);
            lcd_events_due.push_back(
               lcd_event_type'{EV_WAIT, RS_DATA, 4'h0, 16'd2000, 1'b0});
         end
         OP_SETPOS: begin
            if (r.row < 3)
               addr = 128 + (int'(r.row) - 1) * 64 + int'(r.column) - 1;
            else
               addr = 128 + (int'(r.row) - 3) * 64 + 20 + int'(r.column) - 1;
            queue_byte(RS_INSTR, VALUE_W'(addr));
         end
         OP_CURSOR:  queue_byte(RS_INSTR, r.value[0] ? 8'h0F : 8'h0C);
         default: ;
      endcase
      if (lcd_events_due.size() > due_before)
         lcd_events_due[lcd_events_due.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_event(input lcd_event_type want, input lcd_event_type got);
      bit bad;
      bad = 1'b0;
      if (got.kind !== want.kind) begin
         $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
         bad = 1'b1;
      end
      if (got.rs !== want.rs) begin
         $error("reg_select: expected %0d, got %0d", want.rs, got.rs);
         bad = 1'b1;
      end
      if (got.nibble !== want.nibble) begin
         $error("nibble: expected %h, got %h", want.nibble, got.nibble);
         bad = 1'b1;
      end
      if (got.duration !== want.duration) begin
         $error("duration_us: expected %0d, got %0d", want.duration, got.duration);
         bad = 1'b1;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         bad = 1'b1;
      end
      if (bad)
         failures++;
   endfunction

   always @(posedge clock) begin : event_monitor
      lcd_event_type observed;
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = '{rsp_event_kind, rsp_reg_select, rsp_nibble, rsp_duration_us, rsp_last};
         events_seen++;
         if (lcd_events_due.size() == 0) begin
            $error("unexpected event: kind %0d nibble %h duration %0d",
                   rsp_event_kind, rsp_nibble, rsp_duration_us);
            failures++;
         end else begin
            check_event(lcd_events_due.pop_front(), observed);
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (any_taken)
            idle = 0;
         else
            idle++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_row(input stim_row_type r);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_opcode = r.opcode;
      req_value  = r.value;
      req_row    = r.row;
      req_column = r.column;
      req_valid  = 1'b1;
      do @(posedge clock); while (req_stall);
      if (r.typed) begin
         if (r.n_typed > 0) lcd_events_due.push_back(r.ev0);
         if (r.n_typed > 1) lcd_events_due.push_back(r.ev1);
         if (r.n_typed > 2) lcd_events_due.push_back(r.ev2);
      end else begin
         predict_events(r);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_events();
      req_valid = 1'b0;
      while (lcd_events_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_ENABLE_PULSE)
         pulse_us = data[PULSE_W-1:0];
      else
         settle_us = data;
   endtask

   initial begin
      stim_row_type r;
      logic [CSR_DATA_W-1:0] pw;
      logic [CSR_DATA_W-1:0] sw;
      int pick;
      int counted;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = '0;
      req_value  = '0;
      req_row    = '0;
      req_column = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      pulse_us   = 10'd50;
      settle_us  = 12'd250;
      gap_pct    = 20;
      stall_pct  = 20;
      calm       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i])
         send_row(dir_tab[i]);
      drain_events();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       begin pw = 12'd1;    sw = 12'd1;    end
            1:       begin pw = 12'd1023; sw = 12'd4095; end
            2:       begin pw = 12'd1024; sw = 12'd0;    end  // pulse wraps to zero
            default: begin pw = CSR_DATA_W'($urandom); sw = CSR_DATA_W'($urandom); end
         endcase
         write_csr(CSR_ENABLE_PULSE, pw);
         write_csr(CSR_SETTLE, sw);
         calm = (ph == 4);
         counted = 0;
         while (counted < ITEMS_PER_PASS) begin
            if ($urandom_range(0, 24) == 0) begin
               gap_pct   = $urandom_range(0, 2) * 15;
               stall_pct = $urandom_range(0, 2) * 15;
            end
            r        = '0;
            r.value  = VALUE_W'($urandom);
            r.row    = ROW_W'($urandom);
            r.column = COLUMN_W'($urandom);
            pick     = $urandom_range(0, 99);
            if (pick < 7)       r.opcode = OP_INIT;
            else if (pick < 30) r.opcode = OP_COMMAND;
            else if (pick < 55) r.opcode = OP_DATA;
            else if (pick < 63) r.opcode = OP_CLEAR;
            else if (pick < 83) r.opcode = OP_SETPOS;
            else if (pick < 95) r.opcode = OP_CURSOR;
            else                r.opcode = pick[0] ? OP_RSVD7 : OP_RSVD6;
            if (r.opcode == OP_SETPOS && $urandom_range(0, 3) != 0) begin
               r.row    = ROW_W'($urandom_range(1, 4));
               r.column = COLUMN_W'($urandom_range(1, 20));
            end
            send_row(r);
            if (r.opcode <= OP_CURSOR)
               counted++;
            if ($urandom_range(0, 59) == 0)
               drain_events();
         end
         drain_events();
      end

      $display("Sent %0d requests, checked %0d events: every opcode incl. reserved ones,",
               items_sent, events_seen);
      $display("wrapped cursor positions, reset/min/max/zero and random pulse and settle times.");
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
